// ===== rtl/core/ibpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ibpt_pkg: shared definitions for the interval bound prune table
// Table geometry, field widths, command codes and scan kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package ibpt_pkg;

  // Table side and derived widths
  localparam int unsigned MaxSpan = 32;
  localparam int unsigned IdxW    = $clog2(MaxSpan);
  localparam int unsigned SpanW   = $clog2(MaxSpan + 1);
  localparam int unsigned AddrW   = 2 * IdxW;
  localparam int unsigned Depth   = MaxSpan * MaxSpan;

  // Bound values, unsigned Q1.16
  localparam int unsigned ValW = 17;
  localparam logic [ValW-1:0] EstReset = 17'h10000;

  // Span register reset value
  localparam logic [SpanW-1:0] SpanReset = SpanW'(30);

  // Command codes
  typedef enum logic [2:0] {
    CmdWrite    = 3'd0,
    CmdOffer    = 3'd1,
    CmdSweep    = 3'd2,
    CmdInterval = 3'd3,
    CmdDuration = 3'd4,
    CmdWindow   = 3'd5
  } cmd_e;

  // What a running scan serves
  typedef enum logic [1:0] {
    KindDur = 2'd0,
    KindWin = 2'd1,
    KindSwp = 2'd2
  } kind_e;

endpackage

`default_nettype wire

// ===== rtl/core/interval_bound_prune_table.sv =====
// Result path: write, offer, unused command, bad index or cached duration query: result
//   registered in the cycle after the input; interval query: read register, then result.
// Duration and window queries scan one column entry per cycle through the bound memory
//   read port. A sweep rescans every unpruned column and row. One item at a time.
// Reset: a clearing pass writes all 1024 bound entries to zero; no input taken.
// ----------------------------------------------------------------------------
// interval_bound_prune_table: triangular lower-bound table with prune flags
// Keeps bounds per (start, duration) in a single-port-write synchronous
// memory, a best estimate, and cached prune flags per duration and start.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_bound_prune_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: span register
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [4:0] start_index, [9:5] duration_index,
                                             // [26:10] value, [31:27] zero
  input  wire logic [2:0]  s_axis_tuser_i,   // [2:0] cmd
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [0] verdict, [7:1] zero
  output logic             m_axis_tuser_o    // [0] bad_index
);

  localparam int unsigned IdxW  = ibpt_pkg::IdxW;
  localparam int unsigned SpanW = ibpt_pkg::SpanW;
  localparam int unsigned AddrW = ibpt_pkg::AddrW;
  localparam int unsigned ValW  = ibpt_pkg::ValW;
  localparam int unsigned MaxSp = ibpt_pkg::MaxSpan;

  // sequencer states
  localparam logic [2:0] StClr   = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StSweep = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [SpanW-1:0] span_q, span_d;
  logic [ValW-1:0]  best_q, best_d;
  logic [MaxSp-1:0] dpruned_q, dpruned_d, dfresh_q, dfresh_d;
  logic [MaxSp-1:0] spruned_q, spruned_d, sfresh_q, sfresh_d;

  logic [SpanW-1:0] scan_v_q, scan_v_d;
  logic [IdxW-1:0]  scan_fix_q, scan_fix_d;
  logic [IdxW-1:0]  scan_end_q, scan_end_d;
  logic             scan_row_q, scan_row_d;
  ibpt_pkg::kind_e  scan_kind_q, scan_kind_d;
  logic             data_vld_q, data_vld_d;

  logic [SpanW-1:0] swp_t_q, swp_t_d;
  logic             swp_row_q, swp_row_d;

  logic             out_vld_q, out_vld_d;
  logic             verdict_q, verdict_d;
  logic             bad_q, bad_d;

  // decode input transaction
  ibpt_pkg::cmd_e   cmd;
  logic [IdxW-1:0]  si, di;
  logic [ValW-1:0]  val;
  logic [SpanW-1:0] n_eff;
  logic             si_bad, di_bad, accept;
  logic [SpanW-1:0] win_lo;

  assign cmd    = ibpt_pkg::cmd_e'(s_axis_tuser_i);
  assign si     = s_axis_tdata_i[IdxW-1:0];
  assign di     = s_axis_tdata_i[2*IdxW-1:IdxW];
  assign val    = s_axis_tdata_i[2*IdxW+ValW-1:2*IdxW];
  assign n_eff  = (span_q > SpanW'(MaxSp)) ? SpanW'(MaxSp) : span_q;
  assign si_bad = {1'b0, si} >= n_eff;
  assign di_bad = {1'b0, di} >= n_eff;
  assign win_lo = (si >= di) ? {1'b0, si - di} : '0;

  assign s_axis_tready_o = (state_q == StIdle) && (!out_vld_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // bound memory: one write port, one registered read port
  logic [ValW-1:0]  mem [ibpt_pkg::Depth];
  logic [ValW-1:0]  rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr, scan_addr;
  logic [ValW-1:0]  mem_wdata;

  assign mem_we    = (state_q == StClr) ||
                     (accept && cmd == ibpt_pkg::CmdWrite && !si_bad && !di_bad);
  assign mem_waddr = (state_q == StClr) ? clr_q : {si, di};
  assign mem_wdata = (state_q == StClr) ? '0 : val;
  assign scan_addr = scan_row_q ? {scan_fix_q, scan_v_q[IdxW-1:0]}
                                : {scan_v_q[IdxW-1:0], scan_fix_q};
  assign mem_raddr = (state_q == StScan) ? scan_addr : {si, di};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // scan step: issue one read, check the one returned last cycle
  logic [SpanW:0] scan_sum;
  logic           issue_ok, hit, scan_done, swp_pr;

  assign scan_sum  = {1'b0, scan_v_q} + {2'b0, scan_fix_q};
  assign issue_ok  = (scan_sum < {1'b0, n_eff}) && (scan_v_q <= {1'b0, scan_end_q});
  assign hit       = data_vld_q && (rdata_q <= best_q);
  assign scan_done = hit || !issue_ok;
  assign swp_pr    = swp_row_q ? spruned_q[swp_t_q[IdxW-1:0]]
                               : dpruned_q[swp_t_q[IdxW-1:0]];

  // sequencer
  logic produce, res_verdict, res_bad;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    span_d      = cfg_we_i ? cfg_wdata_i : span_q;
    best_d      = best_q;
    dpruned_d   = dpruned_q;
    dfresh_d    = dfresh_q;
    spruned_d   = spruned_q;
    sfresh_d    = sfresh_q;
    scan_v_d    = scan_v_q;
    scan_fix_d  = scan_fix_q;
    scan_end_d  = scan_end_q;
    scan_row_d  = scan_row_q;
    scan_kind_d = scan_kind_q;
    data_vld_d  = data_vld_q;
    swp_t_d     = swp_t_q;
    swp_row_d   = swp_row_q;
    produce     = 1'b0;
    res_verdict = 1'b0;
    res_bad     = 1'b0;

    unique case (state_q)
      StClr: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(ibpt_pkg::Depth - 1)) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (accept) begin
          unique case (cmd)
            ibpt_pkg::CmdWrite: begin
              produce = 1'b1;
              res_bad = si_bad || di_bad;
            end
            ibpt_pkg::CmdOffer: begin
              produce = 1'b1;
              if (val < best_q) begin
                best_d      = val;
                dfresh_d    = '0;
                sfresh_d    = '0;
                res_verdict = 1'b1;
              end
            end
            ibpt_pkg::CmdSweep: begin
              state_d   = StSweep;
              swp_t_d   = '0;
              swp_row_d = 1'b0;
            end
            ibpt_pkg::CmdInterval: begin
              if (si_bad || di_bad) begin
                produce = 1'b1;
                res_bad = 1'b1;
              end else begin
                state_d = StRead;
              end
            end
            ibpt_pkg::CmdDuration: begin
              if (di_bad) begin
                produce = 1'b1;
                res_bad = 1'b1;
              end else if (dfresh_q[di]) begin
                produce     = 1'b1;
                res_verdict = dpruned_q[di];
              end else begin
                dfresh_d[di] = 1'b1;
                if (dpruned_q[di]) begin
                  produce     = 1'b1;
                  res_verdict = 1'b1;
                end else begin
                  state_d     = StScan;
                  scan_v_d    = '0;
                  scan_fix_d  = di;
                  scan_end_d  = '1;
                  scan_row_d  = 1'b0;
                  scan_kind_d = ibpt_pkg::KindDur;
                  data_vld_d  = 1'b0;
                end
              end
            end
            ibpt_pkg::CmdWindow: begin
              if (si_bad || di_bad) begin
                produce = 1'b1;
                res_bad = 1'b1;
              end else begin
                state_d     = StScan;
                scan_v_d    = win_lo;
                scan_fix_d  = di;
                scan_end_d  = si;
                scan_row_d  = 1'b0;
                scan_kind_d = ibpt_pkg::KindWin;
                data_vld_d  = 1'b0;
              end
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end

      StRead: begin
        produce     = 1'b1;
        res_verdict = rdata_q > best_q;
        state_d     = StIdle;
      end

      StScan: begin
        data_vld_d = issue_ok && !hit;
        if (issue_ok && !hit) begin
          scan_v_d = scan_v_q + 1'b1;
        end
        if (scan_done) begin
          data_vld_d = 1'b0;
          unique case (scan_kind_q)
            ibpt_pkg::KindDur: begin
              if (!hit) begin
                dpruned_d[scan_fix_q] = 1'b1;
              end
              produce     = 1'b1;
              res_verdict = !hit;
              state_d     = StIdle;
            end
            ibpt_pkg::KindWin: begin
              produce     = 1'b1;
              res_verdict = !hit;
              state_d     = StIdle;
            end
            default: begin
              if (!hit) begin
                if (scan_row_q) begin
                  spruned_d[scan_fix_q] = 1'b1;
                end else begin
                  dpruned_d[scan_fix_q] = 1'b1;
                end
              end
              swp_t_d = swp_t_q + 1'b1;
              state_d = StSweep;
            end
          endcase
        end
      end

      StSweep: begin
        if (swp_t_q >= n_eff) begin
          // columns done: move to rows; rows done: report
          if (!swp_row_q) begin
            swp_row_d = 1'b1;
            swp_t_d   = '0;
          end else begin
            produce = 1'b1;
            state_d = StIdle;
          end
        end else begin
          if (swp_row_q) begin
            sfresh_d[swp_t_q[IdxW-1:0]] = 1'b1;
          end else begin
            dfresh_d[swp_t_q[IdxW-1:0]] = 1'b1;
          end
          if (swp_pr) begin
            swp_t_d = swp_t_q + 1'b1;
          end else begin
            state_d     = StScan;
            scan_v_d    = '0;
            scan_fix_d  = swp_t_q[IdxW-1:0];
            scan_end_d  = '1;
            scan_row_d  = swp_row_q;
            scan_kind_d = ibpt_pkg::KindSwp;
            data_vld_d  = 1'b0;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // hold the result until the sink takes it
    out_vld_d = produce || (out_vld_q && !m_axis_tready_i);
    verdict_d = produce ? res_verdict : verdict_q;
    bad_d     = produce ? res_bad : bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      clr_q       <= '0;
      span_q      <= ibpt_pkg::SpanReset;
      best_q      <= ibpt_pkg::EstReset;
      dpruned_q   <= '0;
      dfresh_q    <= '0;
      spruned_q   <= '0;
      sfresh_q    <= '0;
      scan_v_q    <= '0;
      scan_fix_q  <= '0;
      scan_end_q  <= '0;
      scan_row_q  <= 1'b0;
      scan_kind_q <= ibpt_pkg::KindDur;
      data_vld_q  <= 1'b0;
      swp_t_q     <= '0;
      swp_row_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      verdict_q   <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      span_q      <= span_d;
      best_q      <= best_d;
      dpruned_q   <= dpruned_d;
      dfresh_q    <= dfresh_d;
      spruned_q   <= spruned_d;
      sfresh_q    <= sfresh_d;
      scan_v_q    <= scan_v_d;
      scan_fix_q  <= scan_fix_d;
      scan_end_q  <= scan_end_d;
      scan_row_q  <= scan_row_d;
      scan_kind_q <= scan_kind_d;
      data_vld_q  <= data_vld_d;
      swp_t_q     <= swp_t_d;
      swp_row_q   <= swp_row_d;
      out_vld_q   <= out_vld_d;
      verdict_q   <= verdict_d;
      bad_q       <= bad_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, verdict_q};
  assign m_axis_tuser_o  = bad_q;

`ifndef SYNTH
  // no input taken during the clearing pass or while a command runs
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == StIdle)
    else $error("input ready outside idle");

  // read data is only pending inside a scan
  a_pending_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_vld_q |-> state_q == StScan)
    else $error("pending read outside scan");

  // a rejected command never reports a positive verdict
  a_bad_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && bad_q) |-> !verdict_q)
    else $error("verdict set on bad index");

  // the best estimate only decreases
  a_best_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> best_q <= $past(best_q))
    else $error("best estimate increased");

  // prune flags are only ever set
  a_prune_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(dpruned_q) & ~dpruned_q) == '0) &&
             (($past(spruned_q) & ~spruned_q) == '0))
    else $error("prune flag cleared");
`endif

endmodule

`default_nettype wire
